/* src/utc_pkg.sv */
// ----------------------------------------------------------------------------
// utc_pkg
// Shared widths, field codes, character codes and controller/datapath structs
// for the UTCTime string decoder.
// ----------------------------------------------------------------------------
package utc_pkg;

  localparam int TIME_W = 53;
  localparam int SECS_W = 33;
  localparam int DAYS_W = 16;
  localparam int SUB_W  = 19;
  localparam int POS_W  = 5;

  localparam logic [2:0] FLD_YEAR    = 3'd0;
  localparam logic [2:0] FLD_MONTH   = 3'd1;
  localparam logic [2:0] FLD_DAY     = 3'd2;
  localparam logic [2:0] FLD_HOUR    = 3'd3;
  localparam logic [2:0] FLD_MIN     = 3'd4;
  localparam logic [2:0] FLD_SEC     = 3'd5;
  localparam logic [2:0] FLD_OFF_HR  = 3'd6;
  localparam logic [2:0] FLD_OFF_MIN = 3'd7;

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_Z     = 8'h5A;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;

  typedef struct packed {
    logic       clear;
    logic       store_tens;
    logic       store_field;
    logic [2:0] field;
    logic       set_sign;
    logic       calc_days;
    logic       calc_secs;
    logic       load_result;
    logic       load_invalid;
  } utc_cmd_t;

  typedef struct packed {
    logic       is_digit;
    logic       is_z;
    logic       is_plus;
    logic       is_minus;
    logic [7:0] range_ok;
  } utc_stat_t;

  function automatic logic [8:0] days_before_month(input logic [3:0] month);
    logic [8:0] d;
    unique case (month)
      4'd1:    d = 9'd0;
      4'd2:    d = 9'd31;
      4'd3:    d = 9'd59;
      4'd4:    d = 9'd90;
      4'd5:    d = 9'd120;
      4'd6:    d = 9'd151;
      4'd7:    d = 9'd181;
      4'd8:    d = 9'd212;
      4'd9:    d = 9'd243;
      4'd10:   d = 9'd273;
      4'd11:   d = 9'd304;
      4'd12:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

/* src/utc_if.sv */
// ----------------------------------------------------------------------------
// utc_in_if / utc_out_if
// Valid/ready channels for the character stream and the decoded time.
// ----------------------------------------------------------------------------
interface utc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       start_of_string;

  modport source (output valid, output char_code, output start_of_string, input ready);
  modport sink   (input valid, input char_code, input start_of_string, output ready);
endinterface

interface utc_out_if;
  logic               valid;
  logic               ready;
  logic signed [52:0] time_us;
  logic               valid_res;

  modport source (output valid, output time_us, output valid_res, input ready);
  modport sink   (input valid, input time_us, input valid_res, output ready);
endinterface

/* src/utc_dp.sv */
// ----------------------------------------------------------------------------
// utc_dp
// Field registers, digit and range checks, and the three-step epoch
// arithmetic with the registered result.
// ----------------------------------------------------------------------------
module utc_dp (
  input  logic                            clk,
  input  logic [7:0]                      char_code,
  input  utc_pkg::utc_cmd_t               cmd,
  output utc_pkg::utc_stat_t              stat,
  output logic signed [utc_pkg::TIME_W-1:0] time_us,
  output logic                            valid_res
);
  import utc_pkg::*;

  logic [3:0]  tens_r;
  logic [7:0]  year_r;
  logic [3:0]  month_r;
  logic [4:0]  day_r;
  logic [4:0]  hour_r;
  logic [5:0]  min_r;
  logic [5:0]  sec_r;
  logic        off_neg_r;
  logic [4:0]  off_hr_r;
  logic [5:0]  off_min_r;

  logic [DAYS_W-1:0]        days_r;
  logic signed [SUB_W-1:0]  sub_r;
  logic signed [SECS_W-1:0] secs_r;
  logic signed [TIME_W-1:0] time_r;
  logic                     valid_res_r;

  logic [3:0]  digit;
  logic [6:0]  val;
  logic [7:0]  year_val;

  logic [6:0]  yr_off;
  logic [4:0]  leap_q;
  logic        leap_adj;
  logic [16:0] days_sum;
  logic [16:0] local_s;
  logic [16:0] off_s;
  logic signed [SUB_W-1:0]  sub_nxt;
  logic [SECS_W-1:0]        days_s;
  logic signed [SECS_W-1:0] secs_nxt;
  logic signed [46:0]       scaled;

  // character classes and two-digit value
  assign digit         = char_code[3:0];

  assign val      = 7'({tens_r, 3'b000}) + 7'({tens_r, 1'b0}) + 7'(digit);
  assign year_val = (val < 7'd70) ? 8'(val) + 8'd100 : 8'(val);

  always_comb begin
    stat.is_digit              = (char_code >= CHAR_ZERO) && (char_code <= CHAR_NINE);
    stat.is_z                  = (char_code == CHAR_Z);
    stat.is_plus               = (char_code == CHAR_PLUS);
    stat.is_minus              = (char_code == CHAR_MINUS);
    stat.range_ok              = '1;
    stat.range_ok[FLD_MONTH]   = (val != 7'd0) && (val <= 7'd12);
    stat.range_ok[FLD_DAY]     = (val != 7'd0) && (val <= 7'd31);
    stat.range_ok[FLD_HOUR]    = (val <= 7'd23);
    stat.range_ok[FLD_MIN]     = (val <= 7'd59);
    stat.range_ok[FLD_SEC]     = (val <= 7'd59);
    stat.range_ok[FLD_OFF_HR]  = (val <= 7'd23);
    stat.range_ok[FLD_OFF_MIN] = (val <= 7'd59);
  end

  // day count and seconds within the day, less the offset
  assign yr_off   = 7'(year_r - 8'd70);
  assign leap_q   = 5'((year_r - 8'd68) >> 2);
  assign leap_adj = (year_r[1:0] == 2'b00) && (month_r < 4'd3);
  assign days_sum = 17'(yr_off) * 17'd365 + 17'(days_before_month(month_r))
                  + 17'(leap_q) + 17'(day_r) - 17'd1 - 17'(leap_adj);

  assign local_s = 17'(hour_r) * 17'd3600 + 17'(min_r) * 17'd60 + 17'(sec_r);
  assign off_s   = 17'(off_hr_r) * 17'd3600 + 17'(off_min_r) * 17'd60;
  assign sub_nxt = off_neg_r ? $signed(SUB_W'(local_s)) + $signed(SUB_W'(off_s))
                             : $signed(SUB_W'(local_s)) - $signed(SUB_W'(off_s));

  assign days_s   = SECS_W'(days_r) * SECS_W'(86400);
  assign secs_nxt = $signed(days_s) + SECS_W'(sub_r);
  assign scaled   = 47'(secs_r) * 47'sd15625;

  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      year_r    <= '0;
      month_r   <= '0;
      day_r     <= '0;
      hour_r    <= '0;
      min_r     <= '0;
      sec_r     <= '0;
      off_neg_r <= 1'b0;
      off_hr_r  <= '0;
      off_min_r <= '0;
    end
    if (cmd.store_tens) begin
      tens_r <= digit;
    end else if (cmd.clear) begin
      tens_r <= '0;
    end
    if (cmd.store_field) begin
      unique case (cmd.field)
        FLD_YEAR:    year_r    <= year_val;
        FLD_MONTH:   month_r   <= val[3:0];
        FLD_DAY:     day_r     <= val[4:0];
        FLD_HOUR:    hour_r    <= val[4:0];
        FLD_MIN:     min_r     <= val[5:0];
        FLD_SEC:     sec_r     <= val[5:0];
        FLD_OFF_HR:  off_hr_r  <= val[4:0];
        FLD_OFF_MIN: off_min_r <= val[5:0];
        default:     ;
      endcase
    end
    if (cmd.set_sign) begin
      off_neg_r <= stat.is_minus;
    end
    if (cmd.calc_days) begin
      days_r <= days_sum[DAYS_W-1:0];
      sub_r  <= sub_nxt;
    end
    if (cmd.calc_secs) begin
      secs_r <= secs_nxt;
    end
    if (cmd.load_result) begin
      time_r      <= {scaled, 6'b000000};
      valid_res_r <= 1'b1;
    end else if (cmd.load_invalid) begin
      time_r      <= '0;
      valid_res_r <= 1'b0;
    end
  end

  assign time_us   = time_r;
  assign valid_res = valid_res_r;

endmodule

/* src/utc_ctrl.sv */
// ----------------------------------------------------------------------------
// utc_ctrl
// Character position sequencer and arithmetic step controller; owns the
// handshakes of both channels.
// ----------------------------------------------------------------------------
module utc_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_start,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  utc_pkg::utc_stat_t  stat,
  output utc_pkg::utc_cmd_t   cmd
);
  import utc_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_PARSE = 3'd1;
  localparam logic [2:0] ST_DAYS  = 3'd2;
  localparam logic [2:0] ST_SECS  = 3'd3;
  localparam logic [2:0] ST_SCALE = 3'd4;

  localparam logic [1:0] K_DIGIT = 2'd0;
  localparam logic [1:0] K_TERM  = 2'd1;
  localparam logic [1:0] K_BAD   = 2'd2;

  localparam logic [POS_W-1:0] POS_SEC  = 5'd10;
  localparam logic [POS_W-1:0] POS_SEC2 = 5'd11;
  localparam logic [POS_W-1:0] POS_TERM = 5'd10;
  localparam logic [POS_W-1:0] POS_TERM_SEC = 5'd12;

  logic [2:0]       state_r, state_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic             sp_r, sp_nxt;
  logic             out_valid_r, out_valid_nxt;

  logic             take;
  logic [POS_W-1:0] eff_pos;
  logic             eff_sp;
  logic [POS_W-1:0] term;
  logic [POS_W-1:0] q;
  logic [1:0]       kind;
  logic [2:0]       fld;
  logic             is_tens;

  assign in_ready = ((state_r == ST_IDLE) || (state_r == ST_PARSE))
                  && (!out_valid_r || out_ready);
  assign take     = in_valid && in_ready;
  assign eff_pos  = in_start ? '0 : pos_r;
  assign eff_sp   = in_start ? 1'b0 : sp_r;
  assign term     = eff_sp ? POS_TERM_SEC : POS_TERM;
  assign q        = eff_pos - term - 5'd1;

  // what the current position expects
  always_comb begin
    kind    = K_BAD;
    fld     = FLD_YEAR;
    is_tens = 1'b0;
    priority if (eff_pos < POS_SEC) begin
      kind    = K_DIGIT;
      fld     = eff_pos[3:1];
      is_tens = !eff_pos[0];
    end else if ((eff_pos == POS_SEC) && !eff_sp && stat.is_digit) begin
      kind    = K_DIGIT;
      fld     = FLD_SEC;
      is_tens = 1'b1;
    end else if ((eff_pos == POS_SEC2) && eff_sp) begin
      kind    = K_DIGIT;
      fld     = FLD_SEC;
      is_tens = 1'b0;
    end else if (eff_pos == term) begin
      kind = K_TERM;
    end else if ((eff_pos > term) && (eff_pos <= term + 5'd4)) begin
      kind    = K_DIGIT;
      fld     = q[1] ? FLD_OFF_MIN : FLD_OFF_HR;
      is_tens = !q[0];
    end else begin
      kind = K_BAD;
    end
  end

  always_comb begin
    cmd           = '0;
    cmd.field     = fld;
    state_nxt     = state_r;
    pos_nxt       = pos_r;
    sp_nxt        = sp_r;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      ST_IDLE, ST_PARSE: begin
        if (take && (in_start || (state_r == ST_PARSE))) begin
          cmd.clear = in_start;
          state_nxt = ST_PARSE;
          pos_nxt   = eff_pos;
          sp_nxt    = eff_sp;
          unique case (kind)
            K_DIGIT: begin
              if (!stat.is_digit) begin
                cmd.load_invalid = 1'b1;
                out_valid_nxt    = 1'b1;
                state_nxt        = ST_IDLE;
              end else if (is_tens) begin
                cmd.store_tens = 1'b1;
                pos_nxt        = eff_pos + 5'd1;
                if (fld == FLD_SEC) begin
                  sp_nxt = 1'b1;
                end
              end else if (!stat.range_ok[fld]) begin
                cmd.load_invalid = 1'b1;
                out_valid_nxt    = 1'b1;
                state_nxt        = ST_IDLE;
              end else begin
                cmd.store_field = 1'b1;
                if (fld == FLD_OFF_MIN) begin
                  state_nxt = ST_DAYS;
                end else begin
                  pos_nxt = eff_pos + 5'd1;
                end
              end
            end
            K_TERM: begin
              if (stat.is_z) begin
                state_nxt = ST_DAYS;
              end else if (stat.is_plus || stat.is_minus) begin
                cmd.set_sign = 1'b1;
                pos_nxt      = eff_pos + 5'd1;
              end else begin
                cmd.load_invalid = 1'b1;
                out_valid_nxt    = 1'b1;
                state_nxt        = ST_IDLE;
              end
            end
            default: begin
              cmd.load_invalid = 1'b1;
              out_valid_nxt    = 1'b1;
              state_nxt        = ST_IDLE;
            end
          endcase
        end
      end
      ST_DAYS: begin
        cmd.calc_days = 1'b1;
        state_nxt     = ST_SECS;
      end
      ST_SECS: begin
        cmd.calc_secs = 1'b1;
        state_nxt     = ST_SCALE;
      end
      ST_SCALE: begin
        cmd.load_result = 1'b1;
        out_valid_nxt   = 1'b1;
        state_nxt       = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pos_r       <= '0;
      sp_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      sp_r        <= sp_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_DAYS) || (state_r == ST_SECS) || (state_r == ST_SCALE)) |-> !in_ready)
    else $error("input taken during time arithmetic");

  a_steps_in_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DAYS) |=> (state_r == ST_SECS) && $past(cmd.calc_days))
    else $error("arithmetic steps out of order");

  a_scale_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCALE) |=> out_valid_r && (state_r == ST_IDLE))
    else $error("result not presented after scaling");

  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= 5'd16)
    else $error("character position beyond last offset digit");

  a_sec_pos: assert property (@(posedge clk) disable iff (!rst_n)
    sp_r |-> (pos_r >= POS_SEC2))
    else $error("seconds flag set before seconds field");

endmodule

/* src/utc_time_string_to_epoch.sv */
// A bad character gives its beat on the output in the cycle after it is taken;
// a completing 'Z' or last offset digit gives its beat after the day, second
// and scaling steps. One character is taken per cycle while parsing, unless a
// result beat is stalled on the output; input is held off during those steps.
// Reset (rst_n low, synchronous) leaves the decoder idle with no result pending.
// ----------------------------------------------------------------------------
// utc_time_string_to_epoch
// Decodes a UTCTime character stream into signed microseconds since 1970.
// ----------------------------------------------------------------------------
module utc_time_string_to_epoch (
  input logic       clk,
  input logic       rst_n,
  utc_in_if.sink    in_chan,
  utc_out_if.source out_chan
);
  import utc_pkg::*;

  utc_cmd_t  cmd;
  utc_stat_t stat;

  utc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_start  (in_chan.start_of_string),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  utc_dp u_dp (
    .clk       (clk),
    .char_code (in_chan.char_code),
    .cmd       (cmd),
    .stat      (stat),
    .time_us   (out_chan.time_us),
    .valid_res (out_chan.valid_res)
  );

endmodule

/* tb/sv/utc_epoch_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utc_epoch_checker
// Watches the character and result channels of the UTCTime decoder. Each
// accepted character runs through a local decoder model; any result it
// implies is queued and compared field by field with the next result beat.
// ----------------------------------------------------------------------------
module utc_epoch_checker (
  input  logic clk,
  input  logic rst_n,
  utc_in_if    in_chan,
  utc_out_if   out_chan,
  output int   errors,
  output int   pending
);
  import utc_pkg::*;

  localparam longint SECS_PER_DAY  = 86400;
  localparam longint SECS_PER_HOUR = 3600;
  localparam longint US_PER_SEC    = 1000000;

  typedef struct packed {
    logic [TIME_W-1:0] time_us;
    logic              valid_res;
  } stamp_t;

  stamp_t     stamp_q[$];
  int         mismatch_count = 0;
  int         waiting        = 0;

  logic [4:0] at_char;
  logic       in_string;
  logic       has_seconds;
  logic [3:0] tens_hold;
  logic [7:0] year_since_1900;
  logic [3:0] month_no;
  logic [4:0] day_no;
  logic [4:0] hour_no;
  logic [5:0] minute_no;
  logic [5:0] second_no;
  logic       offset_west;
  logic [4:0] offset_hr;
  logic [5:0] offset_min;

  assign errors  = mismatch_count;
  assign pending = waiting;

  task automatic report_mismatch(input string msg);
    $display("%0t mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  function automatic void restart_string();
    at_char         = '0;
    has_seconds     = 1'b0;
    tens_hold       = '0;
    year_since_1900 = '0;
    month_no        = '0;
    day_no          = '0;
    hour_no         = '0;
    minute_no       = '0;
    second_no       = '0;
    offset_west     = 1'b0;
    offset_hr       = '0;
    offset_min      = '0;
  endfunction

  function automatic longint month_start(input logic [3:0] m);
    case (m)
      4'd2:    return 31;
      4'd3:    return 59;
      4'd4:    return 90;
      4'd5:    return 120;
      4'd6:    return 151;
      4'd7:    return 181;
      4'd8:    return 212;
      4'd9:    return 243;
      4'd10:   return 273;
      4'd11:   return 304;
      4'd12:   return 334;
      default: return 0;
    endcase
  endfunction

  function automatic stamp_t completed_stamp();
    longint y, m, d, hr, mn, sc, days, shift, secs, us;
    stamp_t r;
    y  = year_since_1900;
    m  = month_no;
    d  = day_no;
    hr = hour_no;
    mn = minute_no;
    sc = second_no;
    days = month_start(month_no) + (y - 68) / 4;
    if ((y % 4) == 0 && m < 3) days--;
    days += (y - 70) * 365 + d - 1;
    shift = longint'(offset_hr) * SECS_PER_HOUR + longint'(offset_min) * 60;
    if (offset_west) shift = -shift;
    secs = days * SECS_PER_DAY + hr * SECS_PER_HOUR + mn * 60 + sc - shift;
    us = secs * US_PER_SEC;
    r.time_us   = us[TIME_W-1:0];
    r.valid_res = 1'b1;
    in_string   = 1'b0;
    return r;
  endfunction

  // returns 1 when the character closes the string, good or bad
  function automatic bit decode_char(input logic [7:0] c, input logic sos, output stamp_t r);
    bit         is_digit;
    bit         tens;
    bit         bad;
    int         p;
    int         term;
    int         q;
    int         v;
    logic [2:0] fld;
    r        = '0;
    is_digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
    if (sos) begin
      restart_string();
      in_string = 1'b1;
    end
    if (!in_string) return 0;
    p    = at_char;
    term = has_seconds ? 12 : 10;
    if (p < 10) begin
      fld  = 3'(p / 2);
      tens = (p % 2) == 0;
    end else if (p == 10 && !has_seconds && is_digit) begin
      fld  = FLD_SEC;
      tens = 1'b1;
    end else if (p == 11 && has_seconds) begin
      fld  = FLD_SEC;
      tens = 1'b0;
    end else if (p == term) begin
      if (c == CHAR_Z) begin
        r = completed_stamp();
        return 1;
      end
      if (c == CHAR_PLUS || c == CHAR_MINUS) begin
        offset_west = (c == CHAR_MINUS);
        at_char     = 5'(p + 1);
        return 0;
      end
      in_string = 1'b0;
      return 1;
    end else if (p > term && p <= term + 4) begin
      q    = p - term - 1;
      fld  = 3'(FLD_OFF_HR + q / 2);
      tens = (q % 2) == 0;
    end else begin
      in_string = 1'b0;
      return 1;
    end

    if (!is_digit) begin
      in_string = 1'b0;
      return 1;
    end
    if (tens) begin
      tens_hold = 4'(c - CHAR_ZERO);
      if (fld == FLD_SEC) has_seconds = 1'b1;
      at_char = 5'(p + 1);
      return 0;
    end

    v   = tens_hold * 10 + (c - CHAR_ZERO);
    bad = 1'b0;
    case (fld)
      FLD_YEAR:   year_since_1900 = 8'((v < 70) ? v + 100 : v);
      FLD_MONTH: begin
        bad = (v == 0) || (v > 12);
        month_no = 4'(v);
      end
      FLD_DAY: begin
        bad = (v == 0) || (v > 31);
        day_no = 5'(v);
      end
      FLD_HOUR: begin
        bad = v > 23;
        hour_no = 5'(v);
      end
      FLD_MIN: begin
        bad = v > 59;
        minute_no = 6'(v);
      end
      FLD_SEC: begin
        bad = v > 59;
        second_no = 6'(v);
      end
      FLD_OFF_HR: begin
        bad = v > 23;
        offset_hr = 5'(v);
      end
      default: begin
        bad = v > 59;
        offset_min = 6'(v);
      end
    endcase
    if (bad) begin
      in_string = 1'b0;
      return 1;
    end
    if (fld == FLD_OFF_MIN) begin
      r = completed_stamp();
      return 1;
    end
    at_char = 5'(p + 1);
    return 0;
  endfunction

  always @(posedge clk) begin : watch
    stamp_t got;
    stamp_t want;
    stamp_t fresh;
    if (!rst_n) begin
      restart_string();
      in_string = 1'b0;
    end else begin
      if (out_chan.valid && out_chan.ready) begin
        got.time_us   = out_chan.time_us;
        got.valid_res = out_chan.valid_res;
        if (stamp_q.size() == 0) begin
          report_mismatch("result beat with no result expected");
        end else begin
          want = stamp_q.pop_front();
          if (got.valid_res !== want.valid_res)
            report_mismatch($sformatf("valid_res got %b expected %b",
                                      got.valid_res, want.valid_res));
          if (got.time_us !== want.time_us)
            report_mismatch($sformatf("time_us got %0d expected %0d",
                                      $signed(got.time_us), $signed(want.time_us)));
        end
      end
      if (in_chan.valid && in_chan.ready) begin
        if (decode_char(in_chan.char_code, in_chan.start_of_string, fresh))
          stamp_q.push_back(fresh);
      end
    end
    waiting = stamp_q.size();
  end

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives UTCTime character strings into the decoder: a few directed strings
// for the time extremes, leap handling and each kind of rejection, then
// random strings, some well formed, some with out-of-range fields, stray
// bytes or cut short. Both channels stall at random; the checker beside the
// decoder predicts and compares every result beat.
// ----------------------------------------------------------------------------
module tb;
  import utc_pkg::*;

  typedef logic [7:0] text_t[$];

  logic clk   = 1'b0;
  logic rst_n = 1'b0;
  int   errors;
  int   pending;
  bit   calm        = 1'b0;
  int   hold_asked  = 0;
  int   hold_served = 0;
  int   chars_sent  = 0;

  utc_in_if  in_chan ();
  utc_out_if out_chan ();

  utc_time_string_to_epoch u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  utc_epoch_checker u_check (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .errors   (errors),
    .pending  (pending)
  );

  always #5 clk = ~clk;

  initial begin
    #3_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // result side: random back-pressure, plus long hold-offs on request
  initial begin
    out_chan.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_served < hold_asked) begin
        hold_served++;
        out_chan.ready <= 1'b0;
        repeat (400) @(posedge clk);
      end else begin
        out_chan.ready <= calm || ($urandom_range(99) >= 17);
      end
    end
  end

  task automatic send_char(input logic [7:0] c, input logic sos);
    while (!calm && $urandom_range(99) < 17) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid           <= 1'b1;
    in_chan.char_code       <= c;
    in_chan.start_of_string <= sos;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    chars_sent++;
  endtask

  task automatic send_text(input text_t s);
    foreach (s[i]) send_char(s[i], i == 0);
  endtask

  function automatic text_t text_of(input string t);
    text_t r;
    foreach (t[i]) r.push_back(t[i]);
    return r;
  endfunction

  function automatic int field_value(input int lo, input int hi, input bit wild);
    if (wild && $urandom_range(7) == 0)
      return (lo == 1 && $urandom_range(1) == 1) ? 0 : $urandom_range(99, hi + 1);
    return $urandom_range(hi, lo);
  endfunction

  function automatic text_t time_text(input bit wild);
    text_t s;
    int    vals[$];
    int    ending;
    vals.push_back($urandom_range(99));
    vals.push_back(field_value(1, 12, wild));
    vals.push_back(field_value(1, 31, wild));
    vals.push_back(field_value(0, 23, wild));
    vals.push_back(field_value(0, 59, wild));
    if ($urandom_range(1) == 1) vals.push_back(field_value(0, 59, wild));
    foreach (vals[i]) begin
      s.push_back(8'(CHAR_ZERO + vals[i] / 10));
      s.push_back(8'(CHAR_ZERO + vals[i] % 10));
    end
    ending = $urandom_range(2);
    if (ending == 0) begin
      s.push_back(CHAR_Z);
    end else begin
      s.push_back(ending == 1 ? CHAR_PLUS : CHAR_MINUS);
      vals.delete();
      vals.push_back(field_value(0, 23, wild));
      vals.push_back(field_value(0, 59, wild));
      foreach (vals[i]) begin
        s.push_back(8'(CHAR_ZERO + vals[i] / 10));
        s.push_back(8'(CHAR_ZERO + vals[i] % 10));
      end
    end
    return s;
  endfunction

  initial begin
    text_t s;
    int    kind;
    int    n;
    in_chan.valid           = 1'b0;
    in_chan.char_code       = '0;
    in_chan.start_of_string = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // stray character while idle is dropped
    send_char(CHAR_Z, 1'b0);
    send_text(text_of("700101000000+2359"));
    send_text(text_of("691231235959-2359"));
    send_text(text_of("0002291200Z"));
    send_text(text_of("7013"));
    send_text(text_of("700100"));
    // new string marked in the middle of another
    send_text(text_of("7"));
    send_text(text_of("7001010000Z"));
    send_text(text_of("70A"));
    send_text(text_of("7001010000X"));

    for (int k = 0; chars_sent < 1850; k++) begin
      calm = (k >= 40 && k < 60);
      if (k == 25) hold_asked++;
      if (k == 90) begin
        in_chan.valid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        @(posedge clk);
      end
      kind = $urandom_range(99);
      if (kind < 55) begin
        s = time_text(1'b0);
      end else if (kind < 80) begin
        s = time_text(1'b1);
      end else if (kind < 92) begin
        s = time_text(1'b0);
        s[$urandom_range(s.size() - 1)] = 8'($urandom_range(255));
      end else begin
        s = time_text($urandom_range(1) == 1);
        n = $urandom_range(s.size() - 1, 1);
        while (s.size() > n) void'(s.pop_back());
      end
      send_text(s);
      if ($urandom_range(9) == 0)
        repeat ($urandom_range(3, 1))
          send_char(8'($urandom_range(255)), $urandom_range(9) == 0);
    end
    in_chan.valid <= 1'b0;
    calm = 1'b0;

    @(posedge clk);
    wait (pending == 0);
    repeat (20) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

/* files.f */
src/utc_pkg.sv
src/utc_if.sv
src/utc_dp.sv
src/utc_ctrl.sv
src/utc_time_string_to_epoch.sv
tb/sv/utc_epoch_checker.sv
tb/sv/tb.sv
